// File: rtl/core/sfv_pkg.sv
// Shared types, format codes and helper functions for the string format validator.
// No dependencies; every module of the validator imports this package.
package sfv_pkg;

	localparam int unsigned MODE_W = 4;

	// Format codes held in the check_mode register.
	localparam logic [MODE_W-1:0] MODE_HMS       = 4'd0;
	localparam logic [MODE_W-1:0] MODE_LOWERCASE = 4'd1;
	localparam logic [MODE_W-1:0] MODE_EMAIL     = 4'd2;
	localparam logic [MODE_W-1:0] MODE_NOQUOTES  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_NOSPACES  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_IPV4      = 4'd5;
	localparam logic [MODE_W-1:0] MODE_HM        = 4'd6;
	localparam logic [MODE_W-1:0] MODE_DIGITS    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_LOWERWORD = 4'd8;
	localparam logic [MODE_W-1:0] MODE_NETMASK   = 4'd9;
	localparam logic [MODE_W-1:0] MODE_LOWERNUM  = 4'd10;
	localparam logic [MODE_W-1:0] MODE_DOTCASE   = 4'd11;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// One classified word as it travels from the front to the back.
	typedef struct packed {
		logic       end_marker;
		logic       is_digit;
		logic [3:0] digit_val;
		logic       is_sep;
		logic       bad;
		logic       is_at;
	} sfv_token_t;

	// Queue status seen by the front and by the top level.
	typedef struct packed {
		logic full;
		logic empty;
	} sfv_q_status_t;

	// Number of numeric fields of a format, zero for the character-class formats.
	function automatic logic [2:0] field_count(input logic [MODE_W-1:0] mode);
		logic [2:0] n;
		unique case (mode)
			MODE_HMS:                n = 3'd3;
			MODE_HM:                 n = 3'd2;
			MODE_IPV4, MODE_NETMASK: n = 3'd4;
			default:                 n = 3'd0;
		endcase
		return n;
	endfunction

	// Largest legal value of a numeric field.
	function automatic logic [8:0] field_limit(input logic [MODE_W-1:0] mode,
			input logic [2:0] idx);
		logic [8:0] lim;
		if (mode == MODE_HMS || mode == MODE_HM) begin
			lim = (idx == 3'd0) ? 9'd23 : 9'd59;
		end else begin
			lim = 9'd255;
		end
		return lim;
	endfunction

endpackage

// File: rtl/core/sfv_front.sv
// Front end of the string format validator: accepts words and classifies each character.
// Depends on sfv_pkg for the format codes and the token type.
module sfv_front import sfv_pkg::*; (
	input  logic [MODE_W-1:0] mode,
	input  logic [7:0]        char_code,
	input  logic              end_marker,
	input  logic              in_valid,
	output logic              in_ready,
	input  sfv_q_status_t     q_status,
	output logic              push,
	output sfv_token_t        push_token
);

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;

	logic is_digit;
	logic is_lower;
	logic is_upper;
	logic is_alnum;
	logic is_sep;
	logic bad;
	logic [7:0] digit_off;

	assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_lower  = (char_code >= 8'h61) && (char_code <= 8'h7A);
	assign is_upper  = (char_code >= 8'h41) && (char_code <= 8'h5A);
	assign is_alnum  = is_digit || is_lower || is_upper;
	assign digit_off = char_code - 8'h30;

	always_comb begin
		is_sep = 1'b0;
		bad    = 1'b0;
		unique case (mode)
			MODE_HMS, MODE_HM: begin
				is_sep = (char_code == CH_COLON);
			end
			MODE_IPV4, MODE_NETMASK: begin
				is_sep = (char_code == CH_DOT);
			end
			MODE_LOWERCASE: bad = is_upper;
			MODE_EMAIL: begin
				bad = !(is_alnum || char_code == CH_DOT || char_code == CH_UNDER ||
					char_code == CH_AT);
			end
			MODE_NOQUOTES: bad = (char_code == CH_DQUOT) || (char_code == CH_SQUOT);
			MODE_NOSPACES: begin
				bad = (char_code == CH_SPACE) ||
					((char_code >= 8'd9) && (char_code <= 8'd13));
			end
			MODE_DIGITS:    bad = !is_digit;
			MODE_LOWERWORD: bad = !is_lower;
			MODE_LOWERNUM:  bad = !(is_lower || is_digit);
			MODE_DOTCASE:   bad = !(is_alnum || char_code == CH_DOT);
			default:        bad = 1'b1;
		endcase
	end

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	assign push_token.end_marker = end_marker;
	assign push_token.is_digit   = is_digit;
	assign push_token.digit_val  = digit_off[3:0];
	assign push_token.is_sep     = is_sep;
	assign push_token.bad        = bad;
	assign push_token.is_at      = (char_code == CH_AT);

endmodule

// File: rtl/core/sfv_queue.sv
// Short FIFO of classified words between the front and the back of the validator.
// Depends on sfv_pkg for the token and status types.
module sfv_queue import sfv_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfv_token_t    push_token,
	input  logic          pop,
	output sfv_token_t    pop_token,
	output sfv_q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sfv_token_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_token    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/sfv_back.sv
// Back end of the string format validator: string state, field checks and result register.
// Depends on sfv_pkg for the format codes, the token type and the field helpers.
module sfv_back import sfv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MODE_W-1:0] mode,
	input  logic              tok_valid,
	input  sfv_token_t        tok,
	output logic              pop,
	output logic              valid_res,
	output logic              out_valid,
	input  logic              out_ready
);

	logic       failed_q;
	logic [2:0] idx_q;
	logic [8:0] fv_q;
	logic [7:0] prev_q;
	logic       ds_q;
	logic [1:0] at_q;
	logic       res_q;
	logic       out_valid_q;

	logic       failed_d;
	logic [2:0] idx_d;
	logic [8:0] fv_d;
	logic [7:0] prev_d;
	logic       ds_d;
	logic [1:0] at_d;
	logic       res_d;

	logic [2:0]  cnt;
	logic        is_field;
	logic        last_field;
	logic        close_fail;
	logic [8:0]  inv;
	logic [11:0] fv_next;

	assign cnt        = field_count(mode);
	assign is_field   = (cnt != 3'd0);
	assign last_field = ({1'b0, idx_q} + 4'd1) >= {1'b0, cnt};

	// A netmask octet must invert to a run of low ones.
	assign inv = {1'b0, ~fv_q[7:0]};
	assign fv_next = {fv_q, 3'b000} + {2'b00, fv_q, 1'b0} + {8'd0, tok.digit_val};

	always_comb begin
		close_fail = !ds_q || (fv_q > field_limit(mode, idx_q));
		if (mode == MODE_NETMASK) begin
			close_fail = close_fail || ((inv & (inv + 9'd1)) != 9'd0) ||
				(fv_q > {1'b0, prev_q});
		end
	end

	// An end word waits in the queue while the result register is still occupied and not being taken.
	assign pop = tok_valid && (!tok.end_marker || !out_valid_q || out_ready);

	always_comb begin
		failed_d = failed_q;
		idx_d    = idx_q;
		fv_d     = fv_q;
		prev_d   = prev_q;
		ds_d     = ds_q;
		at_d     = at_q;
		res_d    = 1'b0;
		if (tok.end_marker) begin
			if (is_field) begin
				res_d = !(failed_q || close_fail ||
					(({1'b0, idx_q} + 4'd1) != {1'b0, cnt}));
			end else if (mode == MODE_EMAIL) begin
				res_d = !failed_q && (at_q == 2'd1);
			end else if (mode > MODE_DOTCASE) begin
				res_d = 1'b0;
			end else begin
				res_d = !failed_q;
			end
			failed_d = 1'b0;
			idx_d    = 3'd0;
			fv_d     = 9'd0;
			prev_d   = 8'd255;
			ds_d     = 1'b0;
			at_d     = 2'd0;
		end else if (is_field) begin
			if (tok.is_digit) begin
				fv_d = (fv_next > 12'd255) ? 9'd256 : fv_next[8:0];
				ds_d = 1'b1;
			end else if (tok.is_sep) begin
				failed_d = failed_q || close_fail || last_field;
				if (mode == MODE_NETMASK) begin
					prev_d = fv_q[7:0];
				end
				fv_d = 9'd0;
				ds_d = 1'b0;
				if (!last_field) begin
					idx_d = idx_q + 3'd1;
				end
			end else begin
				failed_d = 1'b1;
			end
		end else begin
			failed_d = failed_q || tok.bad;
			if (mode == MODE_EMAIL && tok.is_at && at_q != 2'd2) begin
				at_d = at_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q    <= 1'b0;
			idx_q       <= 3'd0;
			fv_q        <= 9'd0;
			prev_q      <= 8'd255;
			ds_q        <= 1'b0;
			at_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				failed_q <= failed_d;
				idx_q    <= idx_d;
				fv_q     <= fv_d;
				prev_q   <= prev_d;
				ds_q     <= ds_d;
				at_q     <= at_d;
			end
			if (pop && tok.end_marker) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.end_marker) begin
			res_q <= res_d;
		end
	end

	assign valid_res = res_q;
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/string_format_validator.sv
// Top level of the string format validator: format register, front, queue and back.
// Depends on sfv_pkg, sfv_front, sfv_queue and sfv_back.
//
// The validator checks an ASCII string, sent one character per input word and
// closed by a word with end_marker set, against the format selected by the
// check_mode register (time, email, IPv4, netmask and several character-class
// formats). Character words produce nothing; the end word produces one output
// word whose valid_res says whether the whole string matched, after which the
// string state is cleared for the next string. The block takes one word per clock
// cycle while in_ready is high. The front classifies each character in the cycle it
// is accepted and writes it to a short queue; the back takes one word per cycle
// from the queue, unless an end word waits behind a pending result, and updates
// the string state; the result of an end word is written to the output register
// once the word leaves the queue. The result sits in that register; while it
// waits to be taken, further character words keep flowing and only a second end
// word waits in the queue. Once the queue fills up behind that end word, in_ready
// drops until the pending result is taken. check_mode is written through cfg_we
// and cfg_wdata and should change only while no string is in flight.
module string_format_validator import sfv_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              end_marker,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              valid_res
);

	logic [MODE_W-1:0] mode_q;
	sfv_q_status_t     q_status;
	logic              push;
	sfv_token_t        push_token;
	logic              pop;
	sfv_token_t        pop_token;

	// Format register; the user must hold its value for every word of a string, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HMS;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	sfv_front u_front (
		.mode       (mode_q),
		.char_code  (char_code),
		.end_marker (end_marker),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.q_status   (q_status),
		.push       (push),
		.push_token (push_token)
	);

	sfv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.pop        (pop),
		.pop_token  (pop_token),
		.status     (q_status)
	);

	sfv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.tok_valid (!q_status.empty),
		.tok       (pop_token),
		.pop       (pop),
		.valid_res (valid_res),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

`ifndef SYNTHESIS
	// The queue is never reported full and empty at once.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty together");

	// The back never pops from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from an empty queue");

	// An end word leaves the queue only when the result register can take it.
	a_end_room: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_token.end_marker) |-> (!out_valid || out_ready))
		else $error("end word popped over a pending result");

	// A popped end word shows its result in the next cycle.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_token.end_marker) |=> out_valid)
		else $error("end word produced no result");
`endif

endmodule

// File: tb/sv/string_format_checker.sv
`timescale 1ns / 1ps
// Result checker for string_format_validator: follows format register writes, predicts
// the verdict of every string and compares each result word. Depends on sfv_pkg.
module string_format_checker import sfv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              end_marker,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              valid_res,
	output int unsigned       fail_count,
	output int unsigned       pending,
	output int unsigned       results_seen,
	output int unsigned       matches_seen
);

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Shadow of the format register and of the per-string state.
	logic [MODE_W-1:0] fmt_mode;
	logic              str_failed;
	logic [2:0]        field_idx;
	logic [8:0]        field_val;
	logic [7:0]        prev_octet;
	logic              digit_seen;
	logic [1:0]        at_count;
	logic              expected_verdicts[$];
	int unsigned       errors;
	int unsigned       checked;
	int unsigned       matched;

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_low(input logic [7:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic logic is_up(input logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic logic is_aln(input logic [7:0] c);
		return is_dig(c) || is_low(c) || is_up(c);
	endfunction

	function automatic logic [2:0] fields_in(input logic [MODE_W-1:0] m);
		case (m)
			MODE_HMS:                return 3'd3;
			MODE_HM:                 return 3'd2;
			MODE_IPV4, MODE_NETMASK: return 3'd4;
			default:                 return 3'd0;
		endcase
	endfunction

	task automatic clear_string();
		str_failed = 1'b0;
		field_idx  = 3'd0;
		field_val  = 9'd0;
		prev_octet = 8'hFF;
		digit_seen = 1'b0;
		at_count   = 2'd0;
	endtask

	task automatic close_field(input logic [MODE_W-1:0] m);
		logic [8:0] lim;
		logic [7:0] inv;
		if (m == MODE_HMS || m == MODE_HM) begin
			lim = (field_idx == 3'd0) ? 9'd23 : 9'd59;
		end else begin
			lim = 9'd255;
		end
		if (!digit_seen || field_val > lim)
			str_failed = 1'b1;
		if (m == MODE_NETMASK) begin
			// A prefix mask inverted is a run of low ones, so adding one clears it.
			inv = ~field_val[7:0];
			if ((inv & (inv + 8'd1)) != 8'd0 || field_val > {1'b0, prev_octet})
				str_failed = 1'b1;
			prev_octet = field_val[7:0];
		end
		field_val  = 9'd0;
		digit_seen = 1'b0;
	endtask

	task automatic take_char(input logic [MODE_W-1:0] m, input logic [7:0] c);
		logic [7:0] sep;
		int unsigned acc;
		if (fields_in(m) != 3'd0) begin
			sep = (m == MODE_IPV4 || m == MODE_NETMASK) ? "." : ":";
			if (is_dig(c)) begin
				acc = int'(field_val) * 10 + int'(c - "0");
				field_val  = (acc > 255) ? 9'd256 : acc[8:0];
				digit_seen = 1'b1;
			end else if (c == sep) begin
				close_field(m);
				if (field_idx + 3'd1 < fields_in(m))
					field_idx = field_idx + 3'd1;
				else
					str_failed = 1'b1;
			end else begin
				str_failed = 1'b1;
			end
		end else begin
			case (m)
				MODE_LOWERCASE: if (is_up(c)) str_failed = 1'b1;
				MODE_EMAIL: begin
					if (c == "@" && at_count < 2'd2)
						at_count = at_count + 2'd1;
					if (!(c == "." || c == "_" || c == "@" || is_aln(c)))
						str_failed = 1'b1;
				end
				MODE_NOQUOTES: if (c == CH_DQUOTE || c == CH_SQUOTE) str_failed = 1'b1;
				MODE_NOSPACES: if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) str_failed = 1'b1;
				MODE_DIGITS: if (!is_dig(c)) str_failed = 1'b1;
				MODE_LOWERWORD: if (!is_low(c)) str_failed = 1'b1;
				MODE_LOWERNUM: if (!is_low(c) && !is_dig(c)) str_failed = 1'b1;
				MODE_DOTCASE: if (!is_aln(c) && c != ".") str_failed = 1'b1;
				default: str_failed = 1'b1;
			endcase
		end
	endtask

	task automatic finish_string(input logic [MODE_W-1:0] m, output logic verdict);
		logic [2:0] n;
		n = fields_in(m);
		if (n != 3'd0) begin
			if (field_idx + 3'd1 != n)
				str_failed = 1'b1;
			close_field(m);
			verdict = !str_failed;
		end else if (m == MODE_EMAIL) begin
			verdict = !str_failed && at_count == 2'd1;
		end else if (m > MODE_DOTCASE) begin
			verdict = 1'b0;
		end else begin
			verdict = !str_failed;
		end
		clear_string();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic verdict;
		logic want;
		if (!arst_n) begin
			fmt_mode = MODE_HMS;
			clear_string();
			expected_verdicts.delete();
			errors  = 0;
			checked = 0;
			matched = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: valid_res expected none, actual %0b", $time, valid_res);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					checked++;
					if (valid_res === 1'b1)
						matched++;
					if (valid_res !== want) begin
						$display("%0t: valid_res expected %0b, actual %0b",
							$time, want, valid_res);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (end_marker) begin
					finish_string(fmt_mode, verdict);
					expected_verdicts.push_back(verdict);
				end else begin
					take_char(fmt_mode, char_code);
				end
			end
			if (cfg_we)
				fmt_mode = cfg_wdata;
		end
		fail_count   <= errors;
		pending      <= expected_verdicts.size();
		results_seen <= checked;
		matches_seen <= matched;
	end

endmodule

// File: tb/sv/string_format_validator_tb.sv
`timescale 1ns / 1ps
// Testbench top for string_format_validator: clock, reset, format register writes and
// character stimulus. Depends on sfv_pkg, the validator RTL and string_format_checker.
module string_format_validator_tb;
	import sfv_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int TARGET_WORDS    = 850;
	// The result of an end word shows up once it has passed the queue and the output
	// register; character words that cause no result may still sit in the queue.
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 160;
	// Longest quiet stretch of a correct run is the receiver hold-off above plus
	// a short random stall, so this leaves a wide margin.
	localparam int WATCHDOG_LIMIT  = 2000;

	// Format codes with no meaning; every string must fail under them.
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd12;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        char_code;
	logic              end_marker;
	logic              out_valid;
	logic              out_ready;
	logic              valid_res;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned matches_seen;

	// Characters of the next string, built before it is sent.
	logic [7:0]  text_q[$];
	int unsigned idle_pct     = 0;
	int unsigned stall_pct    = 0;
	int unsigned words_sent   = 0;
	int unsigned strings_sent = 0;
	int unsigned cfg_writes   = 0;
	int unsigned quiet_cycles = 0;
	bit          hold_off_req = 1'b0;

	string_format_validator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.end_marker (end_marker),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.valid_res  (valid_res)
	);

	// The checker sees the same pins as the block and keeps the expected verdicts.
	string_format_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.end_marker   (end_marker),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.valid_res    (valid_res),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.matches_seen (matches_seen)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Receiver: a fresh ready decision at every falling edge outside a hold-off.
	// A hold-off request drops ready for a long counted stretch so that the block backs up.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Watchdog: any accepted word on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one word. Valid rises at a falling edge after any random gap and
	// stays up with the same payload until the block takes the word. The task
	// returns right after the accepting rising edge, so the caller either offers
	// the next word or lowers valid at the very next falling edge.
	task automatic send_word(input logic [7:0] c, input logic e);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		char_code  <= c;
		end_marker <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// Close the current string. The character field of an end word is ignored
	// by the block, so it carries random bits.
	task automatic end_word();
		send_word(8'($urandom_range(0, 255)), 1'b1);
		strings_sent++;
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++)
			send_word(text_q[i], 1'b0);
		end_word();
	endtask

	// Stop offering, wait until every predicted result has been taken, then give
	// character words still inside the block time to pass through.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Format writes only happen with the block drained.
	task automatic write_mode(input logic [MODE_W-1:0] m);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	task automatic set_idling(input int phase);
		case (phase)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 63;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 63;
			end
			default: begin
				idle_pct  = 27;
				stall_pct = 27;
			end
		endcase
	endtask

	// Index into the set lowercase, uppercase, digits, '.', '_' (64 characters).
	function automatic logic [7:0] pool_char(input int idx);
		if (idx < 26)
			return 8'("a" + idx);
		else if (idx < 52)
			return 8'("A" + (idx - 26));
		else if (idx < 62)
			return 8'("0" + (idx - 52));
		else if (idx == 62)
			return ".";
		else
			return "_";
	endfunction

	// Characters that the formats single out: whitespace, quotes, '@', uppercase.
	function automatic logic [7:0] odd_char();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			return 8'(8'h09 + k);
		case (k)
			5: return " ";
			6: return "\"";
			7: return "'";
			8: return "@";
			default: return "A";
		endcase
	endfunction

	// Decimal text of a value, now and then with a leading zero.
	task automatic push_number(input int v);
		logic [7:0] digs [0:7];
		int cnt;
		cnt = 0;
		if ($urandom_range(0, 9) == 0)
			text_q.push_back("0");
		do begin
			digs[cnt] = 8'("0" + v % 10);
			cnt++;
			v = v / 10;
		end while (v > 0);
		while (cnt > 0) begin
			cnt--;
			text_q.push_back(digs[cnt]);
		end
	endtask

	// Time, IPv4 and netmask strings. Most are well formed with values spread over
	// the legal range and its edges; the rest carry overflowing or saturating
	// values, empty fields, stray characters or the wrong number of fields.
	task automatic build_fields(input logic [MODE_W-1:0] m);
		int n, nf, lim, r, k, top_k, i;
		logic [7:0] sep;
		bit is_time;
		is_time = (m == MODE_HMS || m == MODE_HM);
		n   = (m == MODE_HMS) ? 3 : (m == MODE_HM) ? 2 : 4;
		sep = is_time ? ":" : ".";
		nf  = ($urandom_range(0, 99) < 8) ? $urandom_range(1, n + 1) : n;
		top_k = 8;
		for (i = 0; i < nf; i++) begin
			if (i > 0)
				text_q.push_back(sep);
			lim = is_time ? ((i == 0) ? 23 : 59) : 255;
			r = $urandom_range(0, 99);
			if (m == MODE_NETMASK && r < 80) begin
				// Prefix masks, mostly never wider than the octet before.
				k = (r < 72) ? $urandom_range(0, top_k) : $urandom_range(0, 8);
				top_k = k;
				push_number((32'hFF00 >> k) & 32'hFF);
			end else if (r < 70) begin
				push_number($urandom_range(0, lim));
			end else if (r < 82) begin
				push_number(lim - 1 + $urandom_range(0, 2));
			end else if (r < 90) begin
				push_number($urandom_range(lim + 1, 99999));
			end else if (r >= 95) begin
				text_q.push_back(odd_char());
			end
			// Anything in between leaves the field empty.
		end
	endtask

	// Character-class and email strings: mostly characters the format allows,
	// mixed with any code at all and with the characters formats reject.
	task automatic build_chars(input logic [MODE_W-1:0] m);
		int len, r, k, i, at_first, at_second;
		logic [7:0] c;
		len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
		at_first  = -1;
		at_second = -1;
		if (m == MODE_EMAIL) begin
			// Usually one '@'; sometimes a second one, sometimes none.
			r = $urandom_range(0, 99);
			if (r < 85)
				at_first = $urandom_range(0, len);
			if (r >= 75 && r < 85)
				at_second = $urandom_range(0, len);
		end
		for (i = 0; i <= len; i++) begin
			if (i == at_first)
				text_q.push_back("@");
			if (i == at_second)
				text_q.push_back("@");
			if (i < len) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					c = odd_char();
				end else if (r < 16) begin
					c = 8'($urandom_range(0, 255));
				end else begin
					case (m)
						MODE_LOWERCASE: begin
							c = 8'($urandom_range(32, 126));
							if (c >= "A" && c <= "Z")
								c = c + 8'd32;
						end
						MODE_EMAIL: c = pool_char($urandom_range(0, 63));
						MODE_NOQUOTES, MODE_NOSPACES: c = 8'($urandom_range(33, 126));
						MODE_DIGITS: c = pool_char($urandom_range(52, 61));
						MODE_LOWERWORD: c = pool_char($urandom_range(0, 25));
						MODE_LOWERNUM: begin
							k = $urandom_range(0, 35);
							c = pool_char((k < 26) ? k : k + 26);
						end
						default: c = pool_char($urandom_range(0, 62));
					endcase
				end
				text_q.push_back(c);
			end
		end
	endtask

	initial begin
		int seg, n_str;
		logic [MODE_W-1:0] fmt;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = MODE_HMS;
		in_valid   = 1'b0;
		char_code  = 8'h00;
		end_marker = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed strings, no idling. The register still holds its reset value,
		// H:M:S, and an empty string fails it.
		end_word();
		// The lowest and highest codes belong to no class, so lowercase takes them.
		write_mode(MODE_LOWERCASE);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		end_word();
		// An empty string passes a character-class format.
		write_mode(MODE_DIGITS);
		end_word();
		// IPv4 with an empty field and too few fields.
		write_mode(MODE_IPV4);
		send_word(".", 1'b0);
		end_word();
		// H:M with a separator past the last field.
		write_mode(MODE_HM);
		send_word("1", 1'b0);
		send_word(":", 1'b0);
		send_word("2", 1'b0);
		send_word(":", 1'b0);
		end_word();
		// A lone '@' is all the email format asks for.
		write_mode(MODE_EMAIL);
		send_word("@", 1'b0);
		end_word();
		// Netmask with a single octet.
		write_mode(MODE_NETMASK);
		send_word("9", 1'b0);
		end_word();
		// Unused format codes fail whatever the string holds.
		write_mode(MODE_UNUSED_LO);
		send_word("a", 1'b0);
		end_word();
		write_mode(MODE_UNUSED_HI);
		end_word();
		// Format switched in the middle of a string: 'a' is judged as a lowercase
		// word, 'Z' and the end word under the dotted alphanumeric format.
		write_mode(MODE_LOWERWORD);
		send_word("a", 1'b0);
		write_mode(MODE_DOTCASE);
		send_word("Z", 1'b0);
		end_word();

		// Random part in segments. Each segment drains the block, which also makes
		// the sender pause until every result is in, picks an idling mix and a
		// format, and sends a few strings. The first twelve segments walk every
		// format in order; later ones pick at random.
		seg = 0;
		while (words_sent < TARGET_WORDS) begin
			set_idling(seg % 4);
			fmt = (seg < 12) ? MODE_W'(seg) : MODE_W'($urandom_range(0, MODE_DOTCASE));
			write_mode(fmt);
			// The receiver holds off while the sender keeps going, so end words
			// pile up and the block has to push back on its input.
			if (seg == 4 || seg == 10)
				hold_off_req = 1'b1;
			n_str = $urandom_range(3, 8);
			repeat (n_str) begin
				text_q.delete();
				if (fmt == MODE_HMS || fmt == MODE_HM || fmt == MODE_IPV4 ||
						fmt == MODE_NETMASK)
					build_fields(fmt);
				else
					build_chars(fmt);
				send_text();
			end
			seg++;
		end

		wait_drained();
		$display("Covered %0d words in %0d strings over %0d format writes, with gaps,",
			words_sent, strings_sent, cfg_writes);
		$display("stalls and a long hold-off; %0d results checked, %0d of them matches.",
			results_seen, matches_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
